### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the dual stack checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define DSWT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define DSWT_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/dswt_pkg.sv
// ----------------------------------------------------------------------------
// dswt_pkg
// types and codes shared by the dual stack with transfer unit
// ----------------------------------------------------------------------------
`default_nettype none

package dswt_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 5;

    // command codes
    localparam logic [1:0] CMD_PUSH     = 2'd0;
    localparam logic [1:0] CMD_MOVE_A2M = 2'd1;
    localparam logic [1:0] CMD_POP      = 2'd2;
    localparam logic [1:0] CMD_MOVE_M2A = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] main_top;
        logic signed [DATA_W-1:0] aux_top;
        logic [CNT_W-1:0]         main_count;
        logic [CNT_W-1:0]         aux_count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic       main_wr;
        logic       main_from_aux;
        logic       main_dec;
        logic       main_rd;
        logic       aux_wr;
        logic       aux_dec;
        logic       aux_rd;
        logic       cap_main;
        logic       cap_aux;
        logic       stat_we;
        logic [1:0] status;
        logic       out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic main_empty;
        logic main_full;
        logic main_ge2;
        logic aux_empty;
        logic aux_full;
        logic aux_ge2;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/dswt_chan_if.sv
// ----------------------------------------------------------------------------
// dswt_chan_if
// valid/ready channel carrying one item of a given payload type
// ----------------------------------------------------------------------------
`default_nettype none

interface dswt_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/dual_stack_with_transfer_unit.sv
// Two bounded LIFO stacks (main and aux), STACK_DEPTH words each, driven by
// one command per input item: push the value onto main, pop main, move the
// main top onto aux, or move the aux top onto main. Every item returns one
// result with a status (done, source empty, destination full), both tops
// (zero for an empty stack) and both counts (low 5 bits). A rejected command
// leaves both stacks untouched; empty source wins over full destination.
// Sequence: a command that leaves a stack top to be fetched from memory
// (pop, or the source of a move, with two or more entries on it) passes
// through S_CAP, where the new top from the registered read port of the
// stack memory is captured into the cached top register; every item then
// reaches S_DONE, which loads the result register once it is free, and the
// controller returns to accept the next item only after that load. A
// finished result waits in the output register while the next item is taken
// in. No clearing pass after reset: only the fill counters are reset, and
// memory entries are read only after being written.
// ----------------------------------------------------------------------------
// dual_stack_with_transfer_unit
// top level: controller and datapath of the dual stack with transfer
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stack_with_transfer_unit
    import dswt_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dswt_chan_if.sink   i_in,
    dswt_chan_if.source o_out
);

    t_dp_cmd  w_dp_cmd;   // per-cycle datapath command
    t_dp_stat w_dp_stat;  // stack empty/full/two-or-more flags
    logic     w_in_ready;
    logic     w_out_valid;
    t_in_item w_in_item;

    assign w_in_item = i_in.payload;

    // sequencer: decode, memory fetch of the new top, result hand-off
    dswt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_cmd       (w_in_item.cmd),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .i_stat      (w_dp_stat),
        .o_dp        (w_dp_cmd)
    );

    // stack memories, counters and the result register
    dswt_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (w_in_item.value),
        .i_dp    (w_dp_cmd),
        .o_stat  (w_dp_stat),
        .o_item  (o_out.payload)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

`default_nettype wire

### rtl/core/dswt_ram.sv
// ----------------------------------------------------------------------------
// dswt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dswt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/dswt_ctrl.sv
// ----------------------------------------------------------------------------
// dswt_ctrl
// command decode and sequencing for the two stacks
// ----------------------------------------------------------------------------
`default_nettype none

module dswt_ctrl
    import dswt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_cmd,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_dp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CAP  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state,     n_state;
    logic       r_cap_main,  n_cap_main;
    logic       r_cap_aux,   n_cap_aux;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        n_cap_main = r_cap_main;
        n_cap_aux  = r_cap_aux;
        o_dp       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_dp.stat_we = 1'b1;
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (i_stat.main_full) begin
                                o_dp.status = ST_FULL;
                            end else begin
                                o_dp.main_wr = 1'b1;
                            end
                        end
                        CMD_MOVE_A2M: begin
                            if (i_stat.aux_empty) begin
                                o_dp.status = ST_EMPTY;
                            end else if (i_stat.main_full) begin
                                o_dp.status = ST_FULL;
                            end else begin
                                o_dp.main_wr       = 1'b1;
                                o_dp.main_from_aux = 1'b1;
                                o_dp.aux_dec       = 1'b1;
                                o_dp.aux_rd        = i_stat.aux_ge2;
                            end
                        end
                        CMD_POP: begin
                            if (i_stat.main_empty) begin
                                o_dp.status = ST_EMPTY;
                            end else begin
                                o_dp.main_dec = 1'b1;
                                o_dp.main_rd  = i_stat.main_ge2;
                            end
                        end
                        default: begin
                            // move main top onto aux
                            if (i_stat.main_empty) begin
                                o_dp.status = ST_EMPTY;
                            end else if (i_stat.aux_full) begin
                                o_dp.status = ST_FULL;
                            end else begin
                                o_dp.aux_wr   = 1'b1;
                                o_dp.main_dec = 1'b1;
                                o_dp.main_rd  = i_stat.main_ge2;
                            end
                        end
                    endcase
                    n_cap_main = o_dp.main_rd;
                    n_cap_aux  = o_dp.aux_rd;
                    n_state    = (o_dp.main_rd || o_dp.aux_rd) ? S_CAP : S_DONE;
                end
            end
            S_CAP: begin
                o_dp.cap_main = r_cap_main;
                o_dp.cap_aux  = r_cap_aux;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_dp.out_load = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_dp.out_load | (r_out_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap_main  <= 1'b0;
            r_cap_aux   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap_main  <= n_cap_main;
            r_cap_aux   <= n_cap_aux;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/core/dswt_datapath.sv
// ----------------------------------------------------------------------------
// dswt_datapath
// stack memories, fill counters, cached tops and result register
// ----------------------------------------------------------------------------
`default_nettype none

module dswt_datapath
    import dswt_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire t_dp_cmd                  i_dp,
    output t_dp_stat                      o_stat,
    output t_out_item                     o_item
);

    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [FW-1:0]     r_mfill, r_afill;
    logic [DATA_W-1:0] r_mtop, r_atop;
    logic [1:0]        r_status;
    t_out_item         r_out;

    logic [DATA_W-1:0] w_main_wdata;
    logic [DATA_W-1:0] w_main_rdata, w_aux_rdata;
    logic [FW-1:0]     w_main_below, w_aux_below;
    logic [31:0]       w_mcnt, w_acnt;

    // entry under the current top
    assign w_main_below = r_mfill - FW'(2);
    assign w_aux_below  = r_afill - FW'(2);
    assign w_main_wdata = i_dp.main_from_aux ? r_atop : DATA_W'(i_value);

    dswt_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (i_dp.main_wr),
        .i_waddr (r_mfill[AW-1:0]),
        .i_wdata (w_main_wdata),
        .i_re    (i_dp.main_rd),
        .i_raddr (w_main_below[AW-1:0]),
        .o_rdata (w_main_rdata)
    );

    dswt_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_aux_ram (
        .i_clk   (i_clk),
        .i_we    (i_dp.aux_wr),
        .i_waddr (r_afill[AW-1:0]),
        .i_wdata (r_mtop),
        .i_re    (i_dp.aux_rd),
        .i_raddr (w_aux_below[AW-1:0]),
        .o_rdata (w_aux_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mfill <= '0;
            r_afill <= '0;
        end else begin
            if (i_dp.main_wr) begin
                r_mfill <= r_mfill + FW'(1);
            end else if (i_dp.main_dec) begin
                r_mfill <= r_mfill - FW'(1);
            end
            if (i_dp.aux_wr) begin
                r_afill <= r_afill + FW'(1);
            end else if (i_dp.aux_dec) begin
                r_afill <= r_afill - FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp.main_wr) begin
            r_mtop <= w_main_wdata;
        end else if (i_dp.cap_main) begin
            r_mtop <= w_main_rdata;
        end
        if (i_dp.aux_wr) begin
            r_atop <= r_mtop;
        end else if (i_dp.cap_aux) begin
            r_atop <= w_aux_rdata;
        end
        if (i_dp.stat_we) begin
            r_status <= i_dp.status;
        end
        if (i_dp.out_load) begin
            r_out.status     <= r_status;
            r_out.main_top   <= (r_mfill == '0) ? '0 : $signed(r_mtop);
            r_out.aux_top    <= (r_afill == '0) ? '0 : $signed(r_atop);
            r_out.main_count <= w_mcnt[CNT_W-1:0];
            r_out.aux_count  <= w_acnt[CNT_W-1:0];
        end
    end

    // counts are reported modulo 32
    assign w_mcnt = 32'(r_mfill);
    assign w_acnt = 32'(r_afill);

    assign o_stat.main_empty = (r_mfill == '0);
    assign o_stat.main_full  = (r_mfill == FW'(STACK_DEPTH));
    assign o_stat.main_ge2   = (r_mfill >= FW'(2));
    assign o_stat.aux_empty  = (r_afill == '0);
    assign o_stat.aux_full   = (r_afill == FW'(STACK_DEPTH));
    assign o_stat.aux_ge2    = (r_afill >= FW'(2));

    assign o_item = r_out;

endmodule

`default_nettype wire

### rtl/core/dswt_checker.sv
// ----------------------------------------------------------------------------
// dswt_checker
// port level checks of the dual stack with transfer unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dswt_checker
    import dswt_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     i_in_ready,
    input wire logic                     i_out_valid,
    input wire logic                     i_out_ready,
    input wire logic [1:0]               i_status,
    input wire logic signed [DATA_W-1:0] i_main_top,
    input wire logic signed [DATA_W-1:0] i_aux_top,
    input wire logic [CNT_W-1:0]         i_main_count,
    input wire logic [CNT_W-1:0]         i_aux_count
);

    // no result is shown right after reset
    `DSWT_ASSERT_NORST(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // a stalled result holds
    `DSWT_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status) && $stable(i_main_top) && $stable(i_aux_top) && $stable(i_main_count) && $stable(i_aux_count)), "stalled result changed")

    // one item in flight: input closes after an accept
    `DSWT_ASSERT(a_one_item, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "input accepted twice in a row")

    // status is never the unused code
    `DSWT_ASSERT(a_status_code, i_clk, i_rst_n, i_out_valid |-> (i_status == ST_DONE || i_status == ST_EMPTY || i_status == ST_FULL), "bad status code")

    // when both stacks are empty, both tops show zero
    `DSWT_ASSERT(a_empty_top, i_clk, i_rst_n, (i_out_valid && STACK_DEPTH < 32 && i_main_count == '0 && i_aux_count == '0) |-> (i_main_top == '0 && i_aux_top == '0), "empty stack top not zero")

endmodule

bind dual_stack_with_transfer_unit dswt_checker #(.STACK_DEPTH(STACK_DEPTH)) u_dswt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.payload.status),
    .i_main_top   (o_out.payload.main_top),
    .i_aux_top    (o_out.payload.aux_top),
    .i_main_count (o_out.payload.main_count),
    .i_aux_count  (o_out.payload.aux_count)
);

`default_nettype wire

### tb/sv/tb_dual_stack_with_transfer_unit.sv
// ----------------------------------------------------------------------------
// tb_dual_stack_with_transfer_unit
// self-checking bench for the dual stack: a short directed run over the empty,
// full and extreme-value corners, then random command segments, most biased toward
// filling or draining one stack, with random gaps on both channels and one
// long output stall; each result is checked against a behavioral copy of both
// stacks
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dual_stack_with_transfer_unit;
    import dswt_pkg::*;

    localparam int STACK_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1750;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    // command mixes for the random segments
    typedef enum int {
        MIX_FILL_MAIN,
        MIX_FILL_AUX,
        MIX_DRAIN,
        MIX_REFILL_MAIN,
        MIX_EVEN
    } t_mix;

    logic i_clk;
    logic i_rst_n;

    dswt_chan_if #(.t_payload(t_in_item))  in_ch ();
    dswt_chan_if #(.t_payload(t_out_item)) out_ch ();

    dual_stack_with_transfer_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // behavioral copy of both stacks
    logic signed [DATA_W-1:0] main_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] aux_mem  [STACK_DEPTH];
    int                       main_fill;
    int                       aux_fill;

    t_in_item  cmd_queue[$];     // commands waiting to be offered
    t_out_item stack_results[$]; // predicted results, oldest first
    t_out_item want;

    int n_accepted;
    int total_items;
    int fail_cnt;
    bit hold_off;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // prediction: apply one command to the copy and return the result
    // ------------------------------------------------------------------------
    function automatic t_out_item stack_step(t_in_item it);
        t_out_item  res;
        logic [1:0] st;
        st = ST_DONE;
        case (it.cmd)
            CMD_PUSH: begin
                if (main_fill >= STACK_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    main_mem[main_fill] = it.value;
                    main_fill++;
                end
            end
            CMD_MOVE_A2M: begin
                // empty source is reported ahead of a full destination
                if (aux_fill == 0) begin
                    st = ST_EMPTY;
                end else if (main_fill >= STACK_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    main_mem[main_fill] = aux_mem[aux_fill-1];
                    main_fill++;
                    aux_fill--;
                end
            end
            CMD_POP: begin
                if (main_fill == 0) st = ST_EMPTY;
                else main_fill--;
            end
            default: begin
                if (main_fill == 0) begin
                    st = ST_EMPTY;
                end else if (aux_fill >= STACK_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    aux_mem[aux_fill] = main_mem[main_fill-1];
                    aux_fill++;
                    main_fill--;
                end
            end
        endcase
        res.status     = st;
        // an empty stack shows zero as its top
        res.main_top   = (main_fill == 0) ? '0 : main_mem[main_fill-1];
        res.aux_top    = (aux_fill == 0) ? '0 : aux_mem[aux_fill-1];
        res.main_count = main_fill[CNT_W-1:0];
        res.aux_count  = aux_fill[CNT_W-1:0];
        return res;
    endfunction

    // idle percentage per channel: first third sender light / receiver heavy,
    // second third swapped, last third no idling
    function automatic int idle_pct(bit sender);
        if (n_accepted < total_items / 3) return sender ? 15 : 68;
        if (n_accepted < 2 * total_items / 3) return sender ? 68 : 15;
        return 0;
    endfunction

    task automatic add_item(logic [1:0] cmd, logic [31:0] value);
        t_in_item it;
        it.cmd   = cmd;
        it.value = value;
        cmd_queue.push_back(it);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued commands, holds an item until it is taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                stack_results.push_back(stack_step(in_ch.payload));
                n_accepted <= n_accepted + 1;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // item not taken yet, keep it on the bus
            end else if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
                in_ch.valid   <= 1'b1;
                in_ch.payload <= cmd_queue.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compares each result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (stack_results.size() == 0) begin
                    $error("result with no command outstanding: status %0d",
                           out_ch.payload.status);
                    fail_cnt++;
                end else begin
                    want = stack_results.pop_front();
                    check_field("status", 32'(want.status), 32'(out_ch.payload.status));
                    check_field("main_top", want.main_top, out_ch.payload.main_top);
                    check_field("aux_top", want.aux_top, out_ch.payload.aux_top);
                    check_field("main_count", 32'(want.main_count),
                                32'(out_ch.payload.main_count));
                    check_field("aux_count", 32'(want.aux_count),
                                32'(out_ch.payload.aux_count));
                end
            end
            out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= idle_pct(1'b0));
        end
    end

    // ------------------------------------------------------------------------
    // back-pressure: one long output stall early in the no-idle phase, while
    // the sender keeps offering so the unit fills and stalls its input
    // ------------------------------------------------------------------------
    initial begin
        hold_off = 1'b0;
        @(posedge i_clk);
        while (total_items == 0 || n_accepted < 2 * total_items / 3 + 20) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial begin
        #4_000_000;
        $display("[dual_stack_with_transfer_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int   n_rand;
        int   seg_len;
        int   roll;
        t_mix mix;
        logic [1:0]  cmd;
        logic [31:0] value;

        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        main_fill     = 0;
        aux_fill      = 0;
        n_accepted    = 0;
        total_items   = 0;
        fail_cnt      = 0;

        // empty sources on every command that reads a stack, tops shown as zero
        add_item(CMD_POP, 32'h0);
        add_item(CMD_MOVE_A2M, 32'h0);
        add_item(CMD_MOVE_M2A, 32'hFFFF_FFFF);
        // extreme words, then fill main to the top
        add_item(CMD_PUSH, 32'h8000_0000);
        add_item(CMD_PUSH, 32'h7FFF_FFFF);
        add_item(CMD_PUSH, 32'h0000_0000);
        add_item(CMD_PUSH, 32'hFFFF_FFFF);
        repeat (STACK_DEPTH - 4) add_item(CMD_PUSH, $urandom);
        // push onto full main
        add_item(CMD_PUSH, 32'h5A5A_5A5A);
        // aux empty and main full: empty source takes priority
        add_item(CMD_MOVE_A2M, 32'h0);
        add_item(CMD_MOVE_M2A, 32'h0);
        add_item(CMD_MOVE_A2M, 32'h0);
        add_item(CMD_POP, 32'h0);

        // random segments, each with its own command mix, most biased toward one stack behavior
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            seg_len = $urandom_range(8, 48);
            mix     = t_mix'($urandom_range(MIX_FILL_MAIN, MIX_EVEN));
            repeat (seg_len) begin
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL_MAIN:
                        cmd = (roll < 70) ? CMD_PUSH : (roll < 80) ? CMD_MOVE_M2A :
                              (roll < 90) ? CMD_MOVE_A2M : CMD_POP;
                    MIX_FILL_AUX:
                        cmd = (roll < 60) ? CMD_MOVE_M2A : (roll < 90) ? CMD_PUSH :
                              (roll < 95) ? CMD_POP : CMD_MOVE_A2M;
                    MIX_DRAIN:
                        cmd = (roll < 40) ? CMD_POP : (roll < 70) ? CMD_MOVE_A2M :
                              (roll < 90) ? CMD_MOVE_M2A : CMD_PUSH;
                    MIX_REFILL_MAIN:
                        cmd = (roll < 60) ? CMD_MOVE_A2M : (roll < 80) ? CMD_PUSH :
                              (roll < 90) ? CMD_POP : CMD_MOVE_M2A;
                    default:
                        cmd = 2'($urandom_range(0, 3));
                endcase
                case ($urandom_range(0, 9))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'h0000_0000;
                    3:       value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
                add_item(cmd, value);
                n_rand++;
            end
        end
        total_items = cmd_queue.size();

        // synchronous reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every command to be taken and every result checked
        while (cmd_queue.size() > 0 || in_ch.valid || stack_results.size() > 0)
            @(posedge i_clk);
        // catch any stray result after the last one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("[dual_stack_with_transfer_unit] OK");
        else
            $display("[dual_stack_with_transfer_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/dswt_pkg.sv
rtl/core/dswt_chan_if.sv
rtl/core/dswt_ram.sv
rtl/core/dswt_ctrl.sv
rtl/core/dswt_datapath.sv
rtl/core/dual_stack_with_transfer_unit.sv
rtl/core/dswt_checker.sv
tb/sv/tb_dual_stack_with_transfer_unit.sv
